/* hdl/ptri_pkg.sv */
// ----------------------------------------------------------------------------
// ptri_pkg
// Shared types, widths and codes of the planar trilateration pipeline.
// ----------------------------------------------------------------------------
package ptri_pkg;

  localparam int CW    = 32;            // coordinate width
  localparam int RW    = 31;            // range width
  localparam int DW    = CW + 1;        // anchor difference
  localparam int SW    = 2 * RW;        // squared range
  localparam int PW    = 2 * DW;        // difference product
  localparam int BW    = PW + 2;        // right-hand side b1, b2
  localparam int CRW   = PW + 1;        // cross product
  localparam int SPL   = 34;            // low split of b for the wide products
  localparam int NW    = BW + DW + 1;   // numerators nx, ny
  localparam int MW    = NW + 1;        // |n| + |cr|
  localparam int DENW  = CRW + 1;       // 2 |cr|
  localparam int QB    = 34;            // quotient bits kept before saturation
  localparam int FRONT_LAT = 6;
  localparam int PLACE_LAT = QB + 5;

  localparam logic signed [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] POS_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COINC = 2'd1,
    ST_COLIN = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] anchor1_x;
    logic signed [CW-1:0] anchor1_y;
    logic signed [CW-1:0] anchor2_x;
    logic signed [CW-1:0] anchor2_y;
    logic signed [CW-1:0] anchor3_x;
    logic signed [CW-1:0] anchor3_y;
    logic [RW-1:0]        range1;
    logic [RW-1:0]        range2;
    logic [RW-1:0]        range3;
  } req_beat_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [1:0]           status;
  } rsp_beat_t;

  typedef struct packed {
    logic signed [NW-1:0]  nx;
    logic signed [NW-1:0]  ny;
    logic signed [CRW-1:0] cr;
    logic signed [CW-1:0]  x1;
    logic signed [CW-1:0]  y1;
    logic                  coinc;
  } front_t;

  typedef struct packed {
    logic coinc;
    logic colin;
  } flags_t;

endpackage

/* hdl/ptri_front.sv */
// ----------------------------------------------------------------------------
// ptri_front
// Six-stage datapath: anchor differences, products, cross product and the
// two numerators of the linear system.
// ----------------------------------------------------------------------------
module ptri_front
  import ptri_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_vld,
  input  req_beat_t in_beat,
  output logic      out_vld,
  output front_t    out_data
);

  logic [FRONT_LAT-1:0] vld;

  // stage 1
  logic signed [DW-1:0] s1_dx, s1_dy, s1_ax, s1_ay;
  logic signed [CW-1:0] s1_x1, s1_y1;
  logic [RW-1:0]        s1_r1, s1_r2, s1_r3;
  // stage 2
  logic signed [PW-1:0] s2_dxdx, s2_dydy, s2_axax, s2_ayay, s2_dxay, s2_dyax;
  logic [SW-1:0]        s2_q1, s2_q2, s2_q3;
  logic signed [DW-1:0] s2_dx, s2_dy, s2_ax, s2_ay;
  logic signed [CW-1:0] s2_x1, s2_y1;
  logic                 s2_coinc;
  // stage 3
  logic signed [BW-1:0]  s3_b1, s3_b2;
  logic signed [CRW-1:0] s3_cr;
  logic signed [DW-1:0]  s3_dx, s3_dy, s3_ax, s3_ay;
  logic signed [CW-1:0]  s3_x1, s3_y1;
  logic                  s3_coinc;
  // stage 4: split partial products
  logic signed [SPL+DW:0]      s4_b1ay_l, s4_b2dy_l, s4_b2dx_l, s4_b1ax_l;
  logic signed [BW-SPL+DW-1:0] s4_b1ay_h, s4_b2dy_h, s4_b2dx_h, s4_b1ax_h;
  logic signed [CRW-1:0]       s4_cr;
  logic signed [CW-1:0]        s4_x1, s4_y1;
  logic                        s4_coinc;
  // stage 5
  logic signed [NW-1:0]  s5_t1, s5_t2, s5_t3, s5_t4;
  logic signed [CRW-1:0] s5_cr;
  logic signed [CW-1:0]  s5_x1, s5_y1;
  logic                  s5_coinc;

  logic signed [SPL:0]      b1_lo, b2_lo;
  logic signed [BW-SPL-1:0] b1_hi, b2_hi;

  assign b1_lo = $signed({1'b0, s3_b1[SPL-1:0]});
  assign b2_lo = $signed({1'b0, s3_b2[SPL-1:0]});
  assign b1_hi = s3_b1[BW-1:SPL];
  assign b2_hi = s3_b2[BW-1:SPL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx <= DW'(in_beat.anchor2_x) - DW'(in_beat.anchor1_x);
      s1_dy <= DW'(in_beat.anchor2_y) - DW'(in_beat.anchor1_y);
      s1_ax <= DW'(in_beat.anchor3_x) - DW'(in_beat.anchor1_x);
      s1_ay <= DW'(in_beat.anchor3_y) - DW'(in_beat.anchor1_y);
      s1_x1 <= in_beat.anchor1_x;
      s1_y1 <= in_beat.anchor1_y;
      s1_r1 <= in_beat.range1;
      s1_r2 <= in_beat.range2;
      s1_r3 <= in_beat.range3;

      s2_dxdx  <= s1_dx * s1_dx;
      s2_dydy  <= s1_dy * s1_dy;
      s2_axax  <= s1_ax * s1_ax;
      s2_ayay  <= s1_ay * s1_ay;
      s2_dxay  <= s1_dx * s1_ay;
      s2_dyax  <= s1_dy * s1_ax;
      s2_q1    <= SW'(s1_r1) * SW'(s1_r1);
      s2_q2    <= SW'(s1_r2) * SW'(s1_r2);
      s2_q3    <= SW'(s1_r3) * SW'(s1_r3);
      s2_dx    <= s1_dx;
      s2_dy    <= s1_dy;
      s2_ax    <= s1_ax;
      s2_ay    <= s1_ay;
      s2_x1    <= s1_x1;
      s2_y1    <= s1_y1;
      s2_coinc <= (s1_dx == '0) && (s1_dy == '0);

      s3_b1 <= BW'($signed({1'b0, s2_q1})) - BW'($signed({1'b0, s2_q2}))
             + BW'(s2_dxdx) + BW'(s2_dydy);
      s3_b2 <= BW'($signed({1'b0, s2_q1})) - BW'($signed({1'b0, s2_q3}))
             + BW'(s2_axax) + BW'(s2_ayay);
      s3_cr    <= CRW'(s2_dxay) - CRW'(s2_dyax);
      s3_dx    <= s2_dx;
      s3_dy    <= s2_dy;
      s3_ax    <= s2_ax;
      s3_ay    <= s2_ay;
      s3_x1    <= s2_x1;
      s3_y1    <= s2_y1;
      s3_coinc <= s2_coinc;

      s4_b1ay_l <= b1_lo * s3_ay;
      s4_b1ay_h <= b1_hi * s3_ay;
      s4_b2dy_l <= b2_lo * s3_dy;
      s4_b2dy_h <= b2_hi * s3_dy;
      s4_b2dx_l <= b2_lo * s3_dx;
      s4_b2dx_h <= b2_hi * s3_dx;
      s4_b1ax_l <= b1_lo * s3_ax;
      s4_b1ax_h <= b1_hi * s3_ax;
      s4_cr     <= s3_cr;
      s4_x1     <= s3_x1;
      s4_y1     <= s3_y1;
      s4_coinc  <= s3_coinc;

      s5_t1    <= (NW'(s4_b1ay_h) <<< SPL) + NW'(s4_b1ay_l);
      s5_t2    <= (NW'(s4_b2dy_h) <<< SPL) + NW'(s4_b2dy_l);
      s5_t3    <= (NW'(s4_b2dx_h) <<< SPL) + NW'(s4_b2dx_l);
      s5_t4    <= (NW'(s4_b1ax_h) <<< SPL) + NW'(s4_b1ax_l);
      s5_cr    <= s4_cr;
      s5_x1    <= s4_x1;
      s5_y1    <= s4_y1;
      s5_coinc <= s4_coinc;

      out_data.nx    <= s5_t1 - s5_t2;
      out_data.ny    <= s5_t3 - s5_t4;
      out_data.cr    <= s5_cr;
      out_data.x1    <= s5_x1;
      out_data.y1    <= s5_y1;
      out_data.coinc <= s5_coinc;
    end
  end

  assign out_vld = vld[FRONT_LAT-1];

endmodule

/* hdl/ptri_place.sv */
// ----------------------------------------------------------------------------
// ptri_place
// One coordinate: base + round(n / (2 cr)) by a pipelined restoring divider,
// one quotient bit per stage, then clamp to 32 bits.
// ----------------------------------------------------------------------------
module ptri_place
  import ptri_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [NW-1:0]  num,
  input  logic signed [CRW-1:0] cr,
  input  logic signed [CW-1:0]  base,
  output logic                  out_vld,
  output logic signed [CW-1:0]  pos,
  output logic                  sat
);

  logic [PLACE_LAT-1:0] vld;

  // p1: magnitudes
  logic [NW-1:0]        p1_nm;
  logic [CRW-1:0]       p1_cm;
  logic                 p1_neg;
  logic signed [CW-1:0] p1_base;
  // p2: dividend and divisor
  logic [MW-1:0]        p2_num;
  logic [DENW-1:0]      p2_den;
  logic                 p2_neg;
  logic signed [CW-1:0] p2_base;
  // divider chain, index 0 is the entry
  logic [DENW-1:0]      d_rem  [QB+1];
  logic [QB-1:0]        d_bits [QB+1];
  logic [QB-1:0]        d_q    [QB+1];
  logic [DENW-1:0]      d_den  [QB+1];
  logic                 d_neg  [QB+1];
  logic                 d_ovf  [QB+1];
  logic signed [CW-1:0] d_base [QB+1];
  // sign stage
  logic signed [QB+1:0] g_q;
  logic                 g_neg, g_ovf;
  logic signed [CW-1:0] g_base;

  logic signed [QB+2:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PLACE_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_nm   <= num[NW-1] ? NW'(-num) : NW'(num);
      p1_cm   <= cr[CRW-1] ? CRW'(-cr) : CRW'(cr);
      p1_neg  <= num[NW-1] ^ cr[CRW-1];
      p1_base <= base;

      p2_num  <= MW'(p1_nm) + MW'(p1_cm);
      p2_den  <= {p1_cm, 1'b0};
      p2_neg  <= p1_neg;
      p2_base <= p1_base;

      // a quotient of 2^QB or more saturates whatever the base
      d_ovf[0]  <= p2_num >= MW'({p2_den, {QB{1'b0}}});
      d_rem[0]  <= p2_num[QB+DENW-1:QB];
      d_bits[0] <= p2_num[QB-1:0];
      d_q[0]    <= '0;
      d_den[0]  <= p2_den;
      d_neg[0]  <= p2_neg;
      d_base[0] <= p2_base;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DENW:0] trial;
    logic          take;

    assign trial = {d_rem[k], d_bits[k][QB-1]};
    assign take  = trial >= {1'b0, d_den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k+1]  <= take ? DENW'(trial - {1'b0, d_den[k]}) : DENW'(trial);
        d_bits[k+1] <= d_bits[k] << 1;
        d_q[k+1]    <= {d_q[k][QB-2:0], take};
        d_den[k+1]  <= d_den[k];
        d_neg[k+1]  <= d_neg[k];
        d_ovf[k+1]  <= d_ovf[k];
        d_base[k+1] <= d_base[k];
      end
    end
  end

  assign sum = (QB+3)'(g_q) + (QB+3)'(g_base);

  always_ff @(posedge clk) begin
    if (en) begin
      g_q    <= d_neg[QB] ? -$signed({2'b00, d_q[QB]}) : $signed({2'b00, d_q[QB]});
      g_neg  <= d_neg[QB];
      g_ovf  <= d_ovf[QB];
      g_base <= d_base[QB];

      priority if (g_ovf) begin
        pos <= g_neg ? POS_MIN : POS_MAX;
        sat <= 1'b1;
      end else if (sum > (QB+3)'(POS_MAX)) begin
        pos <= POS_MAX;
        sat <= 1'b1;
      end else if (sum < (QB+3)'(POS_MIN)) begin
        pos <= POS_MIN;
        sat <= 1'b1;
      end else begin
        pos <= sum[CW-1:0];
        sat <= 1'b0;
      end
    end
  end

  assign out_vld = vld[PLACE_LAT-1];

endmodule

/* hdl/planar_trilateration_top.sv */
// ----------------------------------------------------------------------------
// planar_trilateration_top
// Two-dimensional trilateration in signed Q16.16 as a fully pipelined
// datapath: one query in, one position out per cycle while not stalled.
// ----------------------------------------------------------------------------
//  channel | signals                  | beat
//  --------+--------------------------+--------------------------------------
//  req     | req_valid, req_ready     | three anchors, three ranges
//  rsp     | rsp_valid, rsp_ready     | pos_x, pos_y, status
//
//  One beat enters per cycle unless the output stalls; a beat passes the 6
//  front stages, the 34-step divider with its clamp, and 1 output register.
//  Reset clears the valid bits only; the payload registers are left alone.
//  The whole pipeline advances together whenever the output register is
//  empty or being drained; req_ready follows that enable, so a stall holds
//  every stage in place and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module planar_trilateration_top
  import ptri_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_beat_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_beat_t rsp
);

  logic   en;
  logic   f_vld;
  front_t f_data;
  logic   px_vld, py_vld;
  logic signed [CW-1:0] px, py;
  logic   px_sat, py_sat;

  // status flags ride alongside the divider
  flags_t flag_dly [PLACE_LAT];

  // advance everything unless a finished beat is waiting
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  ptri_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (req_valid),
    .in_beat  (req),
    .out_vld  (f_vld),
    .out_data (f_data)
  );

  ptri_place u_place_x (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .num     (f_data.nx),
    .cr      (f_data.cr),
    .base    (f_data.x1),
    .out_vld (px_vld),
    .pos     (px),
    .sat     (px_sat)
  );

  ptri_place u_place_y (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .num     (f_data.ny),
    .cr      (f_data.cr),
    .base    (f_data.y1),
    .out_vld (py_vld),
    .pos     (py),
    .sat     (py_sat)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      flag_dly[0].coinc <= f_data.coinc;
      flag_dly[0].colin <= (f_data.cr == '0);
      for (int i = 1; i < PLACE_LAT; i++) begin
        flag_dly[i] <= flag_dly[i-1];
      end
    end
  end

  // output register: coincident anchors win over collinear, then saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= px_vld && py_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (flag_dly[PLACE_LAT-1].coinc) begin
        rsp.pos_x  <= '0;
        rsp.pos_y  <= '0;
        rsp.status <= ST_COINC;
      end else if (flag_dly[PLACE_LAT-1].colin) begin
        rsp.pos_x  <= '0;
        rsp.pos_y  <= '0;
        rsp.status <= ST_COLIN;
      end else begin
        rsp.pos_x  <= px;
        rsp.pos_y  <= py;
        rsp.status <= (px_sat || py_sat) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

/* hdl/ptri_checker.sv */
// ----------------------------------------------------------------------------
// ptri_checker
// Port-level checks of the trilateration pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ptri_checker
  import ptri_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input req_beat_t req,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_beat_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  a_stall_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while the pipeline is stalled");

  a_bad_geom_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_COINC || rsp.status == ST_COLIN)
      |-> rsp.pos_x == '0 && rsp.pos_y == '0)
    else $error("degenerate anchors with a nonzero position");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_SAT
      |-> rsp.pos_x == POS_MAX || rsp.pos_x == POS_MIN
       || rsp.pos_y == POS_MAX || rsp.pos_y == POS_MIN)
    else $error("saturated status without a clamped coordinate");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind planar_trilateration_top ptri_checker u_ptri_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
